[rtl/slnt_pkg.sv]
// Shared types and codes for the sorted line-number table.
// Used by slnt_ctrl, slnt_dp, the top level and the checker; no dependencies.
package slnt_pkg;

	localparam int KEY_W   = 16;
	localparam int LEN_W   = 16;
	localparam int HND_W   = 16;
	localparam int INDEX_W = 8;
	localparam int TOTAL_W = 9;

	typedef enum logic [1:0] {
		OP_STORE  = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_MISSING   = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_TOO_LARGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE     = 3'd0,
		S_DISPATCH = 3'd1,
		S_SCAN     = 3'd2,
		S_SHIFT_UP = 3'd3,
		S_SHIFT_DN = 3'd4,
		S_WRITE    = 3'd5,
		S_RESULT   = 3'd6
	} state_t;

	// pointer/remaining-count preset
	typedef enum logic [1:0] {
		PI_SCAN = 2'd0,
		PI_UP   = 2'd1,
		PI_DN   = 2'd2
	} ptr_init_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_CLR  = 2'd1,
		CNT_INC  = 2'd2,
		CNT_DEC  = 2'd3
	} cnt_op_t;

	// source of the staged result
	typedef enum logic [1:0] {
		RES_ZERO = 2'd0,
		RES_HIT  = 2'd1,
		RES_NEW  = 2'd2
	} res_sel_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
		logic [HND_W-1:0] hnd;
	} entry_t;

	typedef struct packed {
		logic      take;
		logic      ptr_ld;
		ptr_init_t ptr_init;
		logic      rd;
		logic      rd_dn;
		logic      shift_up;
		logic      shift_dn;
		logic      wr_new;
		cnt_op_t   cnt_op;
		logic      pos_ld;
		logic      res_load;
		res_sel_t  res_sel;
		status_t   res_status;
		logic      push;
	} ctl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic too_large;
		logic hit;
		logic eq;
		logic rem_zero;
		logic vld;
		logic full;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/slnt_ctrl.sv]
// Controller state machine for the sorted line-number table.
// Depends on slnt_pkg; drives slnt_dp through ctl_cmd_t, reads dp_stat_t.
module slnt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  slnt_pkg::dp_stat_t  stat,
	output slnt_pkg::ctl_cmd_t  cmd
);

	slnt_pkg::state_t state_q, state_d;
	logic found_q;
	logic exhausted, decide, found;

	assign exhausted = stat.rem_zero && !stat.vld;
	assign decide    = stat.hit || exhausted;
	assign found     = stat.hit && stat.eq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slnt_pkg::S_IDLE;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == slnt_pkg::S_SCAN && decide) begin
				found_q <= found;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slnt_pkg::S_IDLE: begin
				if (in_valid) state_d = slnt_pkg::S_DISPATCH;
			end
			slnt_pkg::S_DISPATCH: begin
				if (stat.op == slnt_pkg::OP_CLEAR) begin
					state_d = slnt_pkg::S_RESULT;
				end else if (stat.op == slnt_pkg::OP_STORE && stat.too_large) begin
					state_d = slnt_pkg::S_RESULT;
				end else begin
					state_d = slnt_pkg::S_SCAN;
				end
			end
			slnt_pkg::S_SCAN: begin
				if (decide) begin
					if (found) begin
						unique case (stat.op)
							slnt_pkg::OP_DELETE: state_d = slnt_pkg::S_SHIFT_DN;
							slnt_pkg::OP_STORE:  state_d = slnt_pkg::S_WRITE;
							default:             state_d = slnt_pkg::S_RESULT;
						endcase
					end else if (stat.op == slnt_pkg::OP_STORE && !stat.full) begin
						state_d = slnt_pkg::S_SHIFT_UP;
					end else begin
						state_d = slnt_pkg::S_RESULT;
					end
				end
			end
			slnt_pkg::S_SHIFT_UP: begin
				if (exhausted) state_d = slnt_pkg::S_WRITE;
			end
			slnt_pkg::S_SHIFT_DN: begin
				if (exhausted) state_d = slnt_pkg::S_RESULT;
			end
			slnt_pkg::S_WRITE: begin
				state_d = slnt_pkg::S_RESULT;
			end
			slnt_pkg::S_RESULT: begin
				if (stat.out_free) state_d = slnt_pkg::S_IDLE;
			end
			default: state_d = slnt_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall       = 1'b1;
		cmd.take       = 1'b0;
		cmd.ptr_ld     = 1'b0;
		cmd.ptr_init   = slnt_pkg::PI_SCAN;
		cmd.rd         = 1'b0;
		cmd.rd_dn      = 1'b0;
		cmd.shift_up   = 1'b0;
		cmd.shift_dn   = 1'b0;
		cmd.wr_new     = 1'b0;
		cmd.cnt_op     = slnt_pkg::CNT_HOLD;
		cmd.pos_ld     = 1'b0;
		cmd.res_load   = 1'b0;
		cmd.res_sel    = slnt_pkg::RES_ZERO;
		cmd.res_status = slnt_pkg::STAT_DONE;
		cmd.push       = 1'b0;
		unique case (state_q)
			slnt_pkg::S_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			slnt_pkg::S_DISPATCH: begin
				if (stat.op == slnt_pkg::OP_CLEAR) begin
					cmd.cnt_op   = slnt_pkg::CNT_CLR;
					cmd.res_load = 1'b1;
				end else if (stat.op == slnt_pkg::OP_STORE && stat.too_large) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = slnt_pkg::STAT_TOO_LARGE;
				end else begin
					cmd.ptr_ld = 1'b1;
				end
			end
			slnt_pkg::S_SCAN: begin
				cmd.rd = !stat.hit && !stat.rem_zero;
				if (decide) begin
					cmd.pos_ld   = 1'b1;
					cmd.res_load = 1'b1;
					if (found) begin
						if (stat.op == slnt_pkg::OP_STORE) begin
							cmd.res_sel = slnt_pkg::RES_NEW;
						end else begin
							cmd.res_sel = slnt_pkg::RES_HIT;
						end
						if (stat.op == slnt_pkg::OP_DELETE) begin
							cmd.ptr_ld   = 1'b1;
							cmd.ptr_init = slnt_pkg::PI_DN;
						end
					end else if (stat.op == slnt_pkg::OP_STORE) begin
						if (stat.full) begin
							cmd.res_status = slnt_pkg::STAT_FULL;
						end else begin
							cmd.res_sel  = slnt_pkg::RES_NEW;
							cmd.ptr_ld   = 1'b1;
							cmd.ptr_init = slnt_pkg::PI_UP;
						end
					end else begin
						cmd.res_status = slnt_pkg::STAT_MISSING;
					end
				end
			end
			slnt_pkg::S_SHIFT_UP: begin
				cmd.rd       = !stat.rem_zero;
				cmd.rd_dn    = 1'b1;
				cmd.shift_up = 1'b1;
			end
			slnt_pkg::S_SHIFT_DN: begin
				cmd.rd       = !stat.rem_zero;
				cmd.shift_dn = 1'b1;
				if (exhausted) cmd.cnt_op = slnt_pkg::CNT_DEC;
			end
			slnt_pkg::S_WRITE: begin
				cmd.wr_new = 1'b1;
				if (!found_q) cmd.cnt_op = slnt_pkg::CNT_INC;
			end
			slnt_pkg::S_RESULT: begin
				cmd.push = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

[rtl/slnt_dp.sv]
// Datapath for the sorted line-number table: entry memory, scan/shift
// pointers, result staging and output register. Depends on slnt_pkg.
module slnt_dp #(
	parameter int TABLE_DEPTH = 256,
	parameter int LINE_LIMIT  = 65534
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [1:0]                           operation,
	input  logic [slnt_pkg::KEY_W-1:0]           line_number,
	input  logic [slnt_pkg::LEN_W-1:0]           payload_length,
	input  logic [slnt_pkg::HND_W-1:0]           payload_handle,
	input  slnt_pkg::ctl_cmd_t                   cmd,
	output slnt_pkg::dp_stat_t                   stat,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic [slnt_pkg::INDEX_W-1:0]         index,
	output logic [slnt_pkg::LEN_W-1:0]           found_length,
	output logic [slnt_pkg::HND_W-1:0]           found_handle,
	output logic [slnt_pkg::TOTAL_W-1:0]         entry_total
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	slnt_pkg::entry_t table_mem_q [TABLE_DEPTH];

	slnt_pkg::op_t                op_q;
	logic [slnt_pkg::KEY_W-1:0]   line_q;
	logic [slnt_pkg::LEN_W-1:0]   len_q;
	logic [slnt_pkg::HND_W-1:0]   hnd_q;

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    rem_q;
	logic [AW-1:0]    ptr_q;
	logic [CW-1:0]    pos_q;
	logic [AW-1:0]    tag_s1;
	logic             vld_s1;
	slnt_pkg::entry_t data_s1;

	slnt_pkg::status_t              res_status_q;
	logic [slnt_pkg::INDEX_W-1:0]   res_index_q;
	logic [slnt_pkg::LEN_W-1:0]     res_len_q;
	logic [slnt_pkg::HND_W-1:0]     res_hnd_q;

	logic                           out_valid_q;
	slnt_pkg::status_t              out_status_q;
	logic [slnt_pkg::INDEX_W-1:0]   out_index_q;
	logic [slnt_pkg::LEN_W-1:0]     out_len_q;
	logic [slnt_pkg::HND_W-1:0]     out_hnd_q;
	logic [slnt_pkg::TOTAL_W-1:0]   out_total_q;

	logic             hit;
	logic [CW-1:0]    scan_pos;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	slnt_pkg::entry_t wr_data;

	// first stored key at or above the search key ends the scan
	assign hit      = vld_s1 && (data_s1.key >= line_q);
	assign scan_pos = hit ? CW'(tag_s1) : count_q;

	assign stat.op        = op_q;
	assign stat.too_large = line_q > slnt_pkg::KEY_W'(LINE_LIMIT);
	assign stat.hit       = hit;
	assign stat.eq        = data_s1.key == line_q;
	assign stat.rem_zero  = rem_q == '0;
	assign stat.vld       = vld_s1;
	assign stat.full      = count_q == CW'(TABLE_DEPTH);
	assign stat.out_free  = !out_valid_q || !out_stall;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= slnt_pkg::op_t'(operation);
			line_q <= line_number;
			len_q  <= payload_length;
			hnd_q  <= payload_handle;
		end
	end

	// scan / shift walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			rem_q   <= '0;
			vld_s1  <= 1'b0;
			count_q <= '0;
		end else begin
			vld_s1 <= cmd.rd;
			if (cmd.ptr_ld) begin
				unique case (cmd.ptr_init)
					slnt_pkg::PI_UP: begin
						ptr_q <= AW'(count_q - CW'(1));
						rem_q <= count_q - scan_pos;
					end
					slnt_pkg::PI_DN: begin
						ptr_q <= AW'(scan_pos + CW'(1));
						rem_q <= count_q - scan_pos - CW'(1);
					end
					default: begin
						ptr_q <= '0;
						rem_q <= count_q;
					end
				endcase
			end else if (cmd.rd) begin
				ptr_q <= cmd.rd_dn ? ptr_q - AW'(1) : ptr_q + AW'(1);
				rem_q <= rem_q - CW'(1);
			end
			unique case (cmd.cnt_op)
				slnt_pkg::CNT_CLR:  count_q <= '0;
				slnt_pkg::CNT_INC:  count_q <= count_q + CW'(1);
				slnt_pkg::CNT_DEC:  count_q <= count_q - CW'(1);
				default:            count_q <= count_q;
			endcase
		end
	end

	// memory write port: new entry, or one step of a shift
	assign wr_en   = cmd.wr_new || (vld_s1 && (cmd.shift_up || cmd.shift_dn));
	assign wr_data = cmd.wr_new ?
		slnt_pkg::entry_t'{key: line_q, len: len_q, hnd: hnd_q} : data_s1;
	always_comb begin
		if (cmd.wr_new) begin
			wr_addr = AW'(pos_q);
		end else if (cmd.shift_up) begin
			wr_addr = tag_s1 + AW'(1);
		end else begin
			wr_addr = tag_s1 - AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			data_s1 <= table_mem_q[ptr_q];
			tag_s1  <= ptr_q;
		end
	end

	// result staging
	always_ff @(posedge clk) begin
		if (cmd.pos_ld) begin
			pos_q <= scan_pos;
		end
		if (cmd.res_load) begin
			unique case (cmd.res_sel)
				slnt_pkg::RES_HIT: begin
					res_status_q <= slnt_pkg::STAT_DONE;
					res_index_q  <= slnt_pkg::INDEX_W'(scan_pos);
					res_len_q    <= data_s1.len;
					res_hnd_q    <= data_s1.hnd;
				end
				slnt_pkg::RES_NEW: begin
					res_status_q <= slnt_pkg::STAT_DONE;
					res_index_q  <= slnt_pkg::INDEX_W'(scan_pos);
					res_len_q    <= len_q;
					res_hnd_q    <= hnd_q;
				end
				default: begin
					res_status_q <= cmd.res_status;
					res_index_q  <= '0;
					res_len_q    <= '0;
					res_hnd_q    <= '0;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_len_q    <= res_len_q;
			out_hnd_q    <= res_hnd_q;
			out_total_q  <= slnt_pkg::TOTAL_W'(count_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign index        = out_index_q;
	assign found_length = out_len_q;
	assign found_handle = out_hnd_q;
	assign entry_total  = out_total_q;

endmodule

[rtl/sorted_line_number_table.sv]
// Top level of the sorted line-number table.
// Depends on slnt_pkg, slnt_ctrl and slnt_dp.

// The table holds up to TABLE_DEPTH entries (line number, payload length,
// payload handle) kept in strictly ascending line-number order in a
// single-port-write, single-read memory. Each input transaction is one
// operation (store, delete, find, clear) and yields exactly one result
// transaction. One operation is in work at a time. The scan walks the
// memory one entry per cycle and stops at the key's position; a shift then
// moves only the tail behind it, so the two walks together cover the table
// once. A store of a new line into a full table ends after the scan with a
// full status and no shift. Clear and stores above the line limit skip the
// scan and go from dispatch straight to the result state. The block returns
// to its idle state after each operation and takes the next input
// transaction there. The result sits in an output register, so a new input
// transaction is taken while the previous result still waits under out_stall;
// only when that register is still full at the end of the next operation
// does the block hold in its result state. No clearing pass follows reset;
// the entry count alone marks which slots hold live data.
module sorted_line_number_table #(
	parameter int TABLE_DEPTH = 256,
	parameter int LINE_LIMIT  = 65534
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [slnt_pkg::KEY_W-1:0]    line_number,
	input  logic [slnt_pkg::LEN_W-1:0]    payload_length,
	input  logic [slnt_pkg::HND_W-1:0]    payload_handle,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [slnt_pkg::INDEX_W-1:0]  index,
	output logic [slnt_pkg::LEN_W-1:0]    found_length,
	output logic [slnt_pkg::HND_W-1:0]    found_handle,
	output logic [slnt_pkg::TOTAL_W-1:0]  entry_total
);

	slnt_pkg::ctl_cmd_t cmd;
	slnt_pkg::dp_stat_t stat;

	// sequencer: dispatch, scan, shift, write, result
	slnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// memory, walker counters, result staging and output register
	slnt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.LINE_LIMIT  (LINE_LIMIT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.operation      (operation),
		.line_number    (line_number),
		.payload_length (payload_length),
		.payload_handle (payload_handle),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.index          (index),
		.found_length   (found_length),
		.found_handle   (found_handle),
		.entry_total    (entry_total)
	);

endmodule

[rtl/slnt_checker.sv]
// Port-level checks for the sorted line-number table, bound to the top.
// Depends on slnt_pkg and sorted_line_number_table.
module slnt_checker #(
	parameter int TABLE_DEPTH = 256
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [1:0]                    status,
	input logic [slnt_pkg::INDEX_W-1:0]  index,
	input logic [slnt_pkg::LEN_W-1:0]    found_length,
	input logic [slnt_pkg::HND_W-1:0]    found_handle,
	input logic [slnt_pkg::TOTAL_W-1:0]  entry_total
);

	// one operation in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an operation is in work");

	// failed operations report no entry
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != slnt_pkg::STAT_DONE |->
		index == '0 && found_length == '0 && found_handle == '0)
		else $error("failed operation carries entry data");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (TABLE_DEPTH >= 512) || (int'(entry_total) <= TABLE_DEPTH))
		else $error("entry total above table depth");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(index)
		&& $stable(found_length) && $stable(found_handle) && $stable(entry_total))
		else $error("stalled result changed");

endmodule

bind sorted_line_number_table slnt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_slnt_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for sorted_line_number_table.
// Depends on rtl/slnt_pkg.sv and the RTL of the block; a table model in the bench
// predicts every result and a checker process compares each one as it leaves the block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Block configuration, matching the defaults of the RTL.
	localparam int TABLE_DEPTH = 256;
	localparam int LINE_LIMIT  = 65534;

	// Longest operation: scan plus a shift over the whole table.
	localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
	// Bound on the wait for outstanding results at the end.
	localparam int DRAIN_LIMIT  = 200000;

	// One expected result transaction.
	typedef struct {
		slnt_pkg::status_t                status;
		logic [slnt_pkg::INDEX_W-1:0]     index;
		logic [slnt_pkg::LEN_W-1:0]       length;
		logic [slnt_pkg::HND_W-1:0]       handle;
		logic [slnt_pkg::TOTAL_W-1:0]     total;
	} line_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [1:0]                       operation = slnt_pkg::OP_FIND;
	logic [slnt_pkg::KEY_W-1:0]       line_number = '0;
	logic [slnt_pkg::LEN_W-1:0]       payload_length = '0;
	logic [slnt_pkg::HND_W-1:0]       payload_handle = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [1:0]                       status;
	logic [slnt_pkg::INDEX_W-1:0]     index;
	logic [slnt_pkg::LEN_W-1:0]       found_length;
	logic [slnt_pkg::HND_W-1:0]       found_handle;
	logic [slnt_pkg::TOTAL_W-1:0]     entry_total;

	// Mirror of the table contents, kept in sorted order like the block's memory.
	logic [slnt_pkg::KEY_W-1:0] tbl_key    [TABLE_DEPTH];
	logic [slnt_pkg::LEN_W-1:0] tbl_length [TABLE_DEPTH];
	logic [slnt_pkg::HND_W-1:0] tbl_handle [TABLE_DEPTH];
	int                         tbl_count = 0;
	int                         max_fill = 0;

	// Results predicted but not yet seen at the output, oldest first.
	line_result_t pending_results[$];

	// Idling controls: the sender and the receiver may each be run back to back.
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	// A nonzero value asks the receiver to hold off the output for a stretch set by that value.
	int rx_hold_req = 0;

	int error_count = 0;
	int results_checked = 0;
	int op_count[4] = '{0, 0, 0, 0};

	sorted_line_number_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.LINE_LIMIT (LINE_LIMIT)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.line_number   (line_number),
		.payload_length(payload_length),
		.payload_handle(payload_handle),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.index         (index),
		.found_length  (found_length),
		.found_handle  (found_handle),
		.entry_total   (entry_total)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Table model: applies one operation to the mirror and returns the
	// result the block must report for it.
	// ------------------------------------------------------------------
	function automatic line_result_t apply_table_op(input slnt_pkg::op_t op,
			input logic [slnt_pkg::KEY_W-1:0] key,
			input logic [slnt_pkg::LEN_W-1:0] len,
			input logic [slnt_pkg::HND_W-1:0] hnd);
		line_result_t r;
		int hit_pos;
		int ins_pos;
		int i;
		r.status = slnt_pkg::STAT_DONE;
		r.index  = '0;
		r.length = '0;
		r.handle = '0;
		// keys are unique, so scanning down leaves the one match (or count)
		hit_pos = tbl_count;
		for (i = tbl_count - 1; i >= 0; i--)
			if (tbl_key[i] == key)
				hit_pos = i;
		case (op)
			slnt_pkg::OP_CLEAR: begin
				for (i = 0; i < TABLE_DEPTH; i++) begin
					tbl_key[i]    = '0;
					tbl_length[i] = '0;
					tbl_handle[i] = '0;
				end
				tbl_count = 0;
			end
			slnt_pkg::OP_STORE: begin
				if (int'(key) > LINE_LIMIT) begin
					r.status = slnt_pkg::STAT_TOO_LARGE;
				end else if (hit_pos < tbl_count) begin
					// overwrite in place, allowed even when full
					tbl_length[hit_pos] = len;
					tbl_handle[hit_pos] = hnd;
					r.index  = hit_pos[slnt_pkg::INDEX_W-1:0];
					r.length = len;
					r.handle = hnd;
				end else if (tbl_count >= TABLE_DEPTH) begin
					r.status = slnt_pkg::STAT_FULL;
				end else begin
					// sorted position: number of keys below the new one
					ins_pos = 0;
					for (i = 0; i < tbl_count; i++)
						if (tbl_key[i] < key)
							ins_pos++;
					for (i = tbl_count; i > ins_pos; i--) begin
						tbl_key[i]    = tbl_key[i-1];
						tbl_length[i] = tbl_length[i-1];
						tbl_handle[i] = tbl_handle[i-1];
					end
					tbl_key[ins_pos]    = key;
					tbl_length[ins_pos] = len;
					tbl_handle[ins_pos] = hnd;
					tbl_count++;
					r.index  = ins_pos[slnt_pkg::INDEX_W-1:0];
					r.length = len;
					r.handle = hnd;
				end
			end
			default: begin
				// find and delete; keys above the limit are never present
				if (hit_pos >= tbl_count) begin
					r.status = slnt_pkg::STAT_MISSING;
				end else begin
					r.index  = hit_pos[slnt_pkg::INDEX_W-1:0];
					r.length = tbl_length[hit_pos];
					r.handle = tbl_handle[hit_pos];
					if (op == slnt_pkg::OP_DELETE) begin
						for (i = hit_pos; i + 1 < tbl_count; i++) begin
							tbl_key[i]    = tbl_key[i+1];
							tbl_length[i] = tbl_length[i+1];
							tbl_handle[i] = tbl_handle[i+1];
						end
						tbl_count--;
						tbl_key[tbl_count]    = '0;
						tbl_length[tbl_count] = '0;
						tbl_handle[tbl_count] = '0;
					end
				end
			end
		endcase
		if (tbl_count > max_fill)
			max_fill = tbl_count;
		r.total = tbl_count[slnt_pkg::TOTAL_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender: one input transaction. Draws a random idle gap when idling
	// is on, then offers the item until the block takes it. in_valid stays high
	// across back-to-back items so it is never lowered and raised in the
	// same time step.
	// ------------------------------------------------------------------
	task automatic send_op(input slnt_pkg::op_t op,
			input logic [slnt_pkg::KEY_W-1:0] key,
			input logic [slnt_pkg::LEN_W-1:0] len,
			input logic [slnt_pkg::HND_W-1:0] hnd);
		int gap;
		line_result_t exp_r;
		gap = tx_idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= op;
		line_number    <= key;
		payload_length <= len;
		payload_handle <= hnd;
		// accepted at the first edge that sees in_stall low
		do @(posedge clk); while (in_stall);
		exp_r = apply_table_op(op, key, len, hnd);
		pending_results.push_back(exp_r);
		op_count[int'(op)]++;
	endtask

	// Store with random payload.
	task automatic store_rand(input logic [slnt_pkg::KEY_W-1:0] key);
		logic [slnt_pkg::LEN_W-1:0] len;
		logic [slnt_pkg::HND_W-1:0] hnd;
		len = 16'($urandom_range(0, 65535));
		hnd = 16'($urandom_range(0, 65535));
		send_op(slnt_pkg::OP_STORE, key, len, hnd);
	endtask

	// ------------------------------------------------------------------
	// Receiver: after each accepted result it may draw a random stall
	// when idling is on. A hold-off request stalls the output for a long stretch,
	// counted here, while the sender keeps offering transactions.
	// ------------------------------------------------------------------
	initial begin : rx_proc
		int n;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				n = rx_hold_req;
				rx_hold_req = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else if (out_valid && !out_stall) begin
				n = rx_idle_on ? $urandom_range(0, 4) : 0;
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Checker: every accepted result against the oldest prediction.
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		line_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t ns: unexpected result, expected none, actual status %0d index %0d",
					$time, status, index);
			end else begin
				exp_r = pending_results.pop_front();
				results_checked++;
				check_field("status", 32'(exp_r.status), 32'(status));
				check_field("index", 32'(exp_r.index), 32'(index));
				check_field("found_length", 32'(exp_r.length), 32'(found_length));
				check_field("found_handle", 32'(exp_r.handle), 32'(found_handle));
				check_field("entry_total", 32'(exp_r.total), 32'(entry_total));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every operation, field extremes, insert at front, middle and end,
	// overwrite, missing lines, the line-number limit, and clear.
	task automatic test_basic_ops();
		send_op(slnt_pkg::OP_CLEAR, 16'd0, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_FIND, 16'd100, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_DELETE, 16'd100, 16'hFFFF, 16'hFFFF);
		send_op(slnt_pkg::OP_STORE, 16'd100, 16'h0000, 16'h0000);
		send_op(slnt_pkg::OP_STORE, 16'd0, 16'hFFFF, 16'hFFFF);
		send_op(slnt_pkg::OP_STORE, 16'd65534, 16'hAAAA, 16'h5555);
		send_op(slnt_pkg::OP_STORE, 16'hFFFF, 16'h5555, 16'hAAAA);
		send_op(slnt_pkg::OP_STORE, 16'd50, 16'h1234, 16'h8001);
		send_op(slnt_pkg::OP_STORE, 16'd100, 16'h1234, 16'hFFFF);
		send_op(slnt_pkg::OP_FIND, 16'd100, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_FIND, 16'd65534, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_FIND, 16'hFFFF, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_DELETE, 16'd50, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_DELETE, 16'd0, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_DELETE, 16'd65534, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_DELETE, 16'd65534, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_FIND, 16'd100, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_DELETE, 16'hFFFF, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_DELETE, 16'd100, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_STORE, 16'd7, 16'h00FF, 16'hFF00);
		send_op(slnt_pkg::OP_STORE, 16'd9, 16'hFF00, 16'h00FF);
		send_op(slnt_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_op(slnt_pkg::OP_FIND, 16'd7, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_STORE, 16'hFFFF, 16'd1, 16'd1);
	endtask

	// Fill the table in shuffled order, then exercise the full-table
	// rejection, overwrite while full, the limit check while full, and
	// the highest index.
	task automatic test_full_table();
		int slot_key[TABLE_DEPTH];
		int i, j, t;
		send_op(slnt_pkg::OP_CLEAR, 16'd0, 16'd0, 16'd0);
		for (i = 0; i < TABLE_DEPTH; i++)
			slot_key[i] = i * 255 + $urandom_range(0, 254);
		for (i = TABLE_DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = slot_key[i];
			slot_key[i] = slot_key[j];
			slot_key[j] = t;
		end
		for (i = 0; i < TABLE_DEPTH; i++)
			store_rand(slot_key[i][slnt_pkg::KEY_W-1:0]);
		// keys stay below 65280, so the limit value itself is a new line
		store_rand(16'd65534);
		store_rand(slot_key[3][slnt_pkg::KEY_W-1:0]);
		store_rand(16'hFFFF);
		send_op(slnt_pkg::OP_FIND, tbl_key[0], 16'd0, 16'd0);
		send_op(slnt_pkg::OP_FIND, tbl_key[TABLE_DEPTH-1], 16'd0, 16'd0);
		send_op(slnt_pkg::OP_DELETE, slot_key[10][slnt_pkg::KEY_W-1:0], 16'd0, 16'd0);
		store_rand(16'd65534);
		send_op(slnt_pkg::OP_FIND, 16'd65534, 16'd0, 16'd0);
		// removing the first entry shifts the whole table
		send_op(slnt_pkg::OP_DELETE, tbl_key[0], 16'd0, 16'd0);
		send_op(slnt_pkg::OP_DELETE, 16'd65534, 16'd0, 16'd0);
		send_op(slnt_pkg::OP_CLEAR, 16'd0, 16'd0, 16'd0);
	endtask

	// The receiver holds off for a long stretch while the sender offers
	// transactions back to back, so the output register fills and the
	// block stalls its input.
	task automatic test_output_backpressure();
		int i;
		tx_idle_on = 1'b0;
		for (i = 0; i < 6; i++)
			store_rand(16'($urandom_range(0, 31)));
		rx_hold_req = 300;
		for (i = 0; i < 30; i++) begin
			if (i % 3 == 0)
				store_rand(16'($urandom_range(0, 31)));
			else
				send_op(slnt_pkg::OP_FIND, 16'($urandom_range(0, 31)), 16'd0, 16'd0);
		end
		tx_idle_on = 1'b1;
	endtask

	// Random phases, each with its own key range and idling mix. Small
	// key ranges give mostly hits and keep the table short; the range
	// near the top hits the line-number limit; the full range toggles
	// every key bit.
	task automatic test_random_ops();
		int phase, n, pick, key_mode;
		logic [slnt_pkg::KEY_W-1:0] key;
		for (phase = 0; phase < 9; phase++) begin
			key_mode   = $urandom_range(0, 3);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			for (n = 0; n < 100; n++) begin
				case (key_mode)
					0:       key = 16'($urandom_range(0, 15));
					1:       key = 16'($urandom_range(0, 127));
					2:       key = 16'($urandom_range(65500, 65535));
					default: key = 16'($urandom_range(0, 65535));
				endcase
				pick = $urandom_range(0, 99);
				if (pick < 45)
					store_rand(key);
				else if (pick < 65)
					send_op(slnt_pkg::OP_DELETE, key, 16'($urandom), 16'($urandom));
				else if (pick < 98)
					send_op(slnt_pkg::OP_FIND, key, 16'($urandom), 16'($urandom));
				else
					send_op(slnt_pkg::OP_CLEAR, key, 16'($urandom), 16'($urandom));
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		int waited;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_key[i]    = '0;
			tbl_length[i] = '0;
			tbl_handle[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_full_table();
		test_output_backpressure();
		test_random_ops();
		in_valid <= 1'b0;

		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			error_count++;
			$display("%0t ns: results missing, expected %0d more, actual 0",
				$time, pending_results.size());
		end

		$display("Sent %0d stores, %0d deletes, %0d finds, %0d clears; checked %0d results.",
			op_count[slnt_pkg::OP_STORE], op_count[slnt_pkg::OP_DELETE],
			op_count[slnt_pkg::OP_FIND], op_count[slnt_pkg::OP_CLEAR], results_checked);
		$display("Table reached %0d entries; %0d mismatches.", max_fill, error_count);
		if (error_count == 0)
			$display("[sorted_line_number_table] OK");
		else
			$display("[sorted_line_number_table] ERROR");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin : watchdog
		#20_000_000;
		$display("%0t ns: timeout", $time);
		$display("[sorted_line_number_table] ERROR");
		$finish;
	end

endmodule

[sorted_line_number_table.f]
rtl/slnt_pkg.sv
rtl/slnt_ctrl.sv
rtl/slnt_dp.sv
rtl/sorted_line_number_table.sv
rtl/slnt_checker.sv
tb/tb_top.sv
